[sv/murmur2_key_hash_top_assert.svh]
// Assertion macros for the MurmurHash2 bucket hasher.
// Needs clk and arst_n in the scope that includes it.
`ifndef MURMUR2_KEY_HASH_TOP_ASSERT_SVH
`define MURMUR2_KEY_HASH_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define MM2H_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define MM2H_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/mm2h_pkg.sv]
// Shared constants, types and helpers of the MurmurHash2 bucket hasher.
// No dependencies.
package mm2h_pkg;

	localparam int unsigned WORD_W      = 32;
	localparam int unsigned VBYTES_W    = 3;
	localparam int unsigned KLEN_W      = 16;
	localparam int unsigned BUCKET_W    = 10;
	localparam int unsigned NUM_BUCKETS = 1024;

	localparam logic [WORD_W-1:0] MUL_M       = 32'h5bd1e995;
	localparam int unsigned       MIX_SHIFT   = 24;
	localparam int unsigned       FIN_SHIFT_A = 13;
	localparam int unsigned       FIN_SHIFT_B = 15;
	localparam logic [WORD_W-1:0] BUCKET_MASK = WORD_W'(NUM_BUCKETS - 1);
	localparam logic [VBYTES_W-1:0] FULL_BYTES = 3'd4;

	typedef logic [WORD_W-1:0] word_t;

	// operand choice of the shared multiplier
	typedef enum logic [2:0] {
		MUL_WORD,
		MUL_KMIX,
		MUL_HASH,
		MUL_TAIL,
		MUL_FIN
	} mul_op_t;

	typedef struct packed {
		word_t hash;
		word_t kmix;
		word_t word;
	} mul_operands_t;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_K1   = 7'b0000010,
		S_K2   = 7'b0000100,
		S_H    = 7'b0001000,
		S_TAIL = 7'b0010000,
		S_FA   = 7'b0100000,
		S_FB   = 7'b1000000
	} state_t;

	// keep the 1 to 3 valid tail bytes of a word
	function automatic word_t tail_bytes(input word_t w, input logic [VBYTES_W-1:0] nb);
		word_t mask;
		mask = '0;
		case (nb)
			3'd1:    mask = 32'h0000_00ff;
			3'd2:    mask = 32'h0000_ffff;
			3'd3:    mask = 32'h00ff_ffff;
			default: mask = '0;
		endcase
		return w & mask;
	endfunction

endpackage

[sv/murmur2_key_hash_top.sv]
// Top level of the MurmurHash2 (32-bit) key hasher with bucket index output.
// Depends on mm2h_pkg, mm2h_mul_unit and murmur2_key_hash_top_assert.svh.

// A key streams in as little-endian 32-bit words; key_length is sampled on
// the first word and XORed with the seed. One constant multiplier is reused
// for every multiply, one pass per cycle, so in_ready is low while a word is
// worked on: after the accept, a middle word runs S_K1, S_K2, S_H (three
// multiplier passes), a last word of four bytes those plus S_FA, S_FB, one
// with 1 to 3 tail bytes S_TAIL, S_FA, S_FB, an empty key S_FA, S_FB, each
// plus any wait for the output register; the result stays there until taken.
module murmur2_key_hash_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  mm2h_pkg::word_t               cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  mm2h_pkg::word_t               data_word,
	input  logic [mm2h_pkg::VBYTES_W-1:0] valid_bytes,
	input  logic                          last_word,
	input  logic [mm2h_pkg::KLEN_W-1:0]   key_length,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mm2h_pkg::BUCKET_W-1:0] bucket_index
);
	import mm2h_pkg::*;

	state_t  state_q;
	word_t   seed_q;
	word_t   h_q;
	word_t   k_q;
	word_t   w_q;
	logic    last_q;
	logic    in_key_q;
	logic    out_valid_q;
	logic [BUCKET_W-1:0] bucket_q;

	logic          accept;
	logic [VBYTES_W-1:0] nb;
	word_t         h_start;
	word_t         h_final;
	mul_op_t       mul_op;
	mul_operands_t mul_opnd;
	word_t         product;
	logic          out_free;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || out_ready;
	assign nb       = (valid_bytes > FULL_BYTES) ? FULL_BYTES : valid_bytes;
	assign h_start  = in_key_q ? h_q : (seed_q ^ WORD_W'(key_length));
	assign h_final  = h_q ^ (h_q >> FIN_SHIFT_B);

	always_comb begin
		case (state_q)
			S_K1:    mul_op = MUL_WORD;
			S_K2:    mul_op = MUL_KMIX;
			S_H:     mul_op = MUL_HASH;
			S_TAIL:  mul_op = MUL_TAIL;
			S_FA:    mul_op = MUL_FIN;
			default: mul_op = MUL_HASH;
		endcase
	end

	assign mul_opnd = '{hash: h_q, kmix: k_q, word: w_q};

	mm2h_mul_unit u_mul (
		.op      (mul_op),
		.opnd    (mul_opnd),
		.product (product)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg_wr_en) begin
			seed_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			h_q         <= '0;
			in_key_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// a finishing key refills the output register itself
			if (out_valid_q && out_ready && state_q != S_FB) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						h_q      <= h_start;
						in_key_q <= 1'b1;
						if (!last_word || nb == FULL_BYTES) begin
							state_q <= S_K1;
						end else if (nb != '0) begin
							state_q <= S_TAIL;
						end else begin
							state_q <= S_FA;
						end
					end
				end
				S_K1: state_q <= S_K2;
				S_K2: state_q <= S_H;
				S_H: begin
					h_q     <= product ^ k_q;
					state_q <= last_q ? S_FA : S_IDLE;
				end
				S_TAIL: begin
					h_q     <= product;
					state_q <= S_FA;
				end
				S_FA: begin
					h_q     <= product;
					state_q <= S_FB;
				end
				S_FB: begin
					// hold until the output register is free
					if (out_free) begin
						h_q         <= h_final;
						in_key_q    <= 1'b0;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			last_q <= last_word;
			// a tail word carries only its valid bytes
			w_q    <= (last_word && nb != FULL_BYTES) ? tail_bytes(data_word, nb) : data_word;
		end
		if (state_q == S_K1 || state_q == S_K2) begin
			k_q <= product;
		end
		if (state_q == S_FB && out_free) begin
			bucket_q <= BUCKET_W'(h_final & BUCKET_MASK);
		end
	end

	assign out_valid    = out_valid_q;
	assign bucket_index = bucket_q;

`include "murmur2_key_hash_top_assert.svh"

	`MM2H_ASSERT_NEXT(a_mid_word_mixes, accept && !last_word, state_q == S_K1, "middle word must start the mix")
	`MM2H_ASSERT_NEXT(a_key_open, accept, in_key_q, "accepted word must open the key")
	`MM2H_ASSERT_NOW(a_result_from_fin, $rose(out_valid_q), $past(state_q) == S_FB, "result without finalization")
	`MM2H_ASSERT_NEXT(a_fin_waits, state_q == S_FB && out_valid_q && !out_ready, state_q == S_FB && $stable(h_q), "finalization must hold while output is busy")

endmodule

[sv/mm2h_mul_unit.sv]
// Shared constant multiplier: picks and preconditions one operand, multiplies by M.
// Depends on mm2h_pkg.
module mm2h_mul_unit (
	input  mm2h_pkg::mul_op_t       op,
	input  mm2h_pkg::mul_operands_t opnd,
	output mm2h_pkg::word_t         product
);
	import mm2h_pkg::*;

	word_t operand;
	logic [2*WORD_W-1:0] full_product;

	always_comb begin
		case (op)
			MUL_WORD: operand = opnd.word;
			MUL_KMIX: operand = opnd.kmix ^ (opnd.kmix >> MIX_SHIFT);
			MUL_HASH: operand = opnd.hash;
			MUL_TAIL: operand = opnd.hash ^ opnd.word;
			MUL_FIN:  operand = opnd.hash ^ (opnd.hash >> FIN_SHIFT_A);
			default:  operand = opnd.hash;
		endcase
	end

	assign full_product = operand * MUL_M;
	assign product      = full_product[WORD_W-1:0];

endmodule

[test/tb.sv]
// Self-checking testbench for murmur2_key_hash_top: streams keys over valid/ready,
// predicts each bucket index and compares it with the block's output.
// Depends on mm2h_pkg and murmur2_key_hash_top.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mm2h_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 1_000_000;
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam int unsigned PHASE_WORDS  = 250;
	localparam int unsigned NUM_PHASES   = 8;
	localparam int unsigned MAX_PRINTS   = 100;

	// data fill of a key
	localparam int FILL_RANDOM = 0;
	localparam int FILL_ZEROS  = 1;
	localparam int FILL_ONES   = 2;

	// Predicts the bucket index of each key from the words the block accepts.
	class bucket_predictor;
		word_t                   seed;
		word_t                   accum;
		bit                      in_key;
		logic [BUCKET_W-1:0]     expected_buckets[$];
		int unsigned             mismatches;

		function new();
			seed = '0;
			accum = '0;
			in_key = 1'b0;
			mismatches = 0;
		endfunction

		function void set_seed(word_t s);
			seed = s;
		endfunction

		function word_t mix(word_t h, word_t w);
			word_t k;
			word_t hm;
			k = w * MUL_M;
			k ^= k >> MIX_SHIFT;
			k = k * MUL_M;
			hm = h * MUL_M;
			return hm ^ k;
		endfunction

		function void note_word(word_t w, logic [VBYTES_W-1:0] nb, logic lst,
				logic [KLEN_W-1:0] klen);
			word_t h;
			word_t fin;
			logic [VBYTES_W-1:0] n;
			if (!in_key) begin
				accum = seed ^ word_t'(klen);
				in_key = 1'b1;
			end
			h = accum;
			if (!lst) begin
				accum = mix(h, w);
				return;
			end
			n = (nb > FULL_BYTES) ? FULL_BYTES : nb;
			if (n == FULL_BYTES) begin
				h = mix(h, w);
			end else if (n != 0) begin
				// fold the low n tail bytes
				h ^= w & ((word_t'(1) << (8 * n)) - 1);
				h = h * MUL_M;
			end
			h ^= h >> FIN_SHIFT_A;
			h = h * MUL_M;
			h ^= h >> FIN_SHIFT_B;
			accum = h;
			in_key = 1'b0;
			fin = h & BUCKET_MASK;
			expected_buckets.push_back(fin[BUCKET_W-1:0]);
		endfunction

		task report_mismatch(string msg);
			if (mismatches < MAX_PRINTS)
				$display("[%0t] ERROR: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_bucket(logic [BUCKET_W-1:0] got);
			logic [BUCKET_W-1:0] want;
			if (expected_buckets.size() == 0) begin
				report_mismatch($sformatf("unexpected bucket_index %0d", got));
				return;
			end
			want = expected_buckets.pop_front();
			if (got !== want)
				report_mismatch($sformatf("bucket_index got %0d, want %0d", got, want));
		endtask

		function int pending();
			return expected_buckets.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	word_t                 cfg_wr_data;
	logic                  in_valid;
	logic                  in_ready;
	word_t                 data_word;
	logic [VBYTES_W-1:0]   valid_bytes;
	logic                  last_word;
	logic [KLEN_W-1:0]     key_length;
	logic                  out_valid;
	logic                  out_ready;
	logic [BUCKET_W-1:0]   bucket_index;

	bucket_predictor sb = new();
	bit              idle_on;
	int unsigned     cycles;
	int unsigned     words_sent;

	murmur2_key_hash_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_word    (data_word),
		.valid_bytes  (valid_bytes),
		.last_word    (last_word),
		.key_length   (key_length),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.bucket_index (bucket_index)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_bucket(bucket_index);
	end

	// receiver back-pressure
	initial begin
		int stall_left;
		stall_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else begin
				out_ready = 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_word(input word_t w, input logic [VBYTES_W-1:0] nb,
			input logic lst, input logic [KLEN_W-1:0] klen);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		data_word = w;
		valid_bytes = nb;
		last_word = lst;
		key_length = klen;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_word(w, nb, lst, klen);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_key(input int nwords, input logic [VBYTES_W-1:0] tail_nb,
			input logic [KLEN_W-1:0] klen, input int fill);
		word_t w;
		for (int i = 0; i < nwords; i++) begin
			case (fill)
				FILL_ZEROS: w = '0;
				FILL_ONES:  w = '1;
				default:    w = $urandom;
			endcase
			// valid_bytes is ignored before the last word, key_length after the first
			if (i == nwords - 1)
				send_word(w, tail_nb, 1'b1, (i == 0) ? klen : KLEN_W'($urandom));
			else
				send_word(w, VBYTES_W'($urandom_range(0, 7)), 1'b0,
					(i == 0) ? klen : KLEN_W'($urandom));
		end
	endtask

	task automatic send_random_key();
		int r;
		int nwords;
		int fill;
		logic [VBYTES_W-1:0] nb;
		logic [KLEN_W-1:0] klen;
		int true_len;
		r = $urandom_range(0, 99);
		if (r < 50)
			nwords = $urandom_range(1, 3);
		else if (r < 90)
			nwords = $urandom_range(4, 8);
		else
			nwords = $urandom_range(9, 24);
		nb = ($urandom_range(0, 99) < 80) ? VBYTES_W'($urandom_range(0, 4))
			: VBYTES_W'($urandom_range(5, 7));
		true_len = 4 * (nwords - 1) + ((nb > FULL_BYTES) ? 4 : int'(nb));
		// a share of keys carry a length that disagrees with the words sent
		klen = ($urandom_range(0, 99) < 85) ? KLEN_W'(true_len)
			: KLEN_W'($urandom_range(0, 65535));
		r = $urandom_range(0, 99);
		fill = (r < 90) ? FILL_RANDOM : (r < 95) ? FILL_ZEROS : FILL_ONES;
		send_key(nwords, nb, klen, fill);
	endtask

	// hold off until the block has nothing left in flight
	task automatic wait_idle();
		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_seed(input word_t s);
		cfg_wr_data = s;
		cfg_wr_en = 1'b1;
		sb.set_seed(s);
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	initial begin
		word_t s;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		data_word = '0;
		valid_bytes = '0;
		last_word = 1'b0;
		key_length = '0;
		idle_on = 1'b1;
		cycles = 0;
		words_sent = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed keys
		write_seed('0);
		send_key(1, 3'd0, 16'd0, FILL_ZEROS);         // empty key
		send_key(1, 3'd1, 16'd1, FILL_ONES);
		send_key(1, 3'd2, 16'd2, FILL_RANDOM);
		send_key(1, 3'd3, 16'd3, FILL_ONES);
		send_key(1, FULL_BYTES, 16'd4, FILL_ONES);   // last word mixed as full
		send_key(1, 3'd5, 16'd4, FILL_RANDOM);        // saturate to four
		send_key(1, 3'd6, 16'd4, FILL_ONES);
		send_key(1, 3'd7, 16'd4, FILL_RANDOM);
		send_key(1, 3'd0, 16'hffff, FILL_ONES);       // empty key, length mismatch
		send_key(2, 3'd3, 16'd7, FILL_ZEROS);
		send_key(3, FULL_BYTES, 16'hffff, FILL_ONES);
		send_key(3, 3'd1, 16'd9, FILL_RANDOM);
		wait_idle();
		write_seed('1);
		send_key(1, 3'd0, 16'd0, FILL_ZEROS);
		send_key(1, FULL_BYTES, 16'hffff, FILL_ONES);
		wait_idle();

		// random keys over several seeds
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0:       s = '1;
				1:       s = '0;
				2:       s = 32'h8000_0000;
				3:       s = 32'h0000_0001;
				default: s = $urandom;
			endcase
			write_seed(s);
			idle_on = (p != 1) && (p != 5);
			words_sent = 0;
			while (words_sent < PHASE_WORDS)
				send_random_key();
			wait_idle();
		end

		if (sb.mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[filelist.f]
+incdir+sv
sv/mm2h_pkg.sv
sv/mm2h_mul_unit.sv
sv/murmur2_key_hash_top.sv
test/tb.sv
